### rtl/core/first_fit_coalescing_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Included by every module that carries concurrent assertions.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFCA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ffca assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ffca assertion failed");

`endif

### rtl/core/ffca_pkg.sv
// Shared types and constants of the first-fit coalescing allocator.
// No dependencies; used by ffca_ctrl, ffca_dp and the top level.
`default_nettype none

package ffca_pkg;

    // Defaults for the top-level parameters.
    localparam int ADDR_BITS_DEF  = 20;
    localparam int FREE_SLOTS_DEF = 16;
    localparam int USED_SLOTS_DEF = 32;

    // Page geometry and pool size after reset.
    localparam int PAGE_SHIFT  = 12;
    localparam int RESET_PAGES = 256;

    // Field widths of a request and a result.
    localparam int SIZE_W   = 21;
    localparam int RADDR_W  = 20;
    localparam int STAT_W   = 3;
    localparam int INUSE_W  = 21;
    localparam int PAGES_W  = 9;
    localparam int TDATA_W  = 48;

    // Request command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_UNKNOWN    = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_BAD_SIZE   = 3'd4
    } status_t;

    // Operations on the free-list scan index.
    typedef enum logic [1:0] {
        FI_HOLD   = 2'd0,
        FI_CLR    = 2'd1,
        FI_INC    = 2'd2,
        FI_LOAD_H = 2'd3
    } fidx_op_t;

    // Free-list write kinds.
    typedef enum logic [2:0] {
        FW_NONE   = 3'd0,
        FW_SPLIT  = 3'd1,
        FW_SHIFT  = 3'd2,
        FW_APPEND = 3'd3,
        FW_FRONT  = 3'd4,
        FW_BACK   = 3'd5,
        FW_JOIN_J = 3'd6,
        FW_JOIN_H = 3'd7
    } fw_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     req_load;
        logic     uidx_inc;
        logic     scan;
        logic     slot_alloc;
        logic     slot_hit;
        fidx_op_t fidx_op;
        logic     rd_next;
        fw_mode_t fw_mode;
        logic     cnt_dec;
        logic     used_wr;
        logic     used_rel;
        logic     grant_load;
        logic     st_load;
        status_t  st_code;
        logic     out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic uvalid;
        logic ulast;
        logic hit;
        logic chk_last;
        logic fend;
        logic list_full;
        logic fit;
        logic rest_zero;
        logic touch_front;
        logic touch_back;
        logic j_is_h;
        logic shift_more;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/first_fit_coalescing_allocator.sv
// Allocate finds the first empty table slot, scans the free list for the first extent that fits
// and, when that extent is used up, shifts the later entries down; free finds the matching slot,
// scans the list for a neighbor, appends when there is none or merges with it, and after a merge
// searches for a second neighbor, joins it and shifts the later entries down.
// One request at a time; the next is accepted in the cycle after a result is queued, even while it
// waits for m_tready. Reset (rst_n, async) and a pool_pages write leave one extent, no blocks.
`default_nettype none

module first_fit_coalescing_allocator #(
    parameter int ADDR_BITS  = ffca_pkg::ADDR_BITS_DEF,
    parameter int FREE_SLOTS = ffca_pkg::FREE_SLOTS_DEF,
    parameter int USED_SLOTS = ffca_pkg::USED_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ffca_pkg::PAGES_W-1:0]  cfg_wr_data,  // pool_pages
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ffca_pkg::TDATA_W-1:0]  s_tdata,      // req_size, req_addr
    input  wire logic [0:0]                    s_tuser,      // cmd
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ffca_pkg::TDATA_W-1:0]       m_tdata       // status, block_addr, bytes_in_use
);
    import ffca_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer.
    ffca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    ffca_dp #(
        .ADDR_BITS  (ADDR_BITS),
        .FREE_SLOTS (FREE_SLOTS),
        .USED_SLOTS (USED_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

### rtl/core/ffca_dp.sv
// Datapath of the allocator: free list, allocated-block table, counters and
// the result register. Depends on ffca_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_coalescing_allocator_defines.svh"

module ffca_dp #(
    parameter int ADDR_BITS  = 20,
    parameter int FREE_SLOTS = 16,
    parameter int USED_SLOTS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ffca_pkg::PAGES_W-1:0]    cfg_wr_data,
    input  wire logic [ffca_pkg::TDATA_W-1:0]    s_tdata,
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ffca_pkg::TDATA_W-1:0]         m_tdata,
    input  wire ffca_pkg::ctrl_cmd_t             cmd,
    output ffca_pkg::dp_stat_t                   stat
);
    import ffca_pkg::*;

    localparam int LEN_W     = ADDR_BITS + 1;
    localparam int FI_W      = $clog2(FREE_SLOTS);
    localparam int CNT_W     = $clog2(FREE_SLOTS + 1);
    localparam int UI_W      = $clog2(USED_SLOTS);
    localparam int CW        = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
    localparam int MAX_PAGES = 1 << (ADDR_BITS - PAGE_SHIFT);
    localparam int RST_PAGES = (RESET_PAGES > MAX_PAGES) ? MAX_PAGES : RESET_PAGES;
    localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(RST_PAGES) << PAGE_SHIFT;
    localparam logic [UI_W-1:0]  ULAST     = UI_W'(USED_SLOTS - 1);

    // Latched request.
    logic                 cmd_free_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    // Free list and its bookkeeping.
    logic [ADDR_BITS-1:0] free_start_reg [FREE_SLOTS];
    logic [LEN_W-1:0]     free_len_reg   [FREE_SLOTS];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     fidx_reg;
    logic [CNT_W-1:0]     hidx_reg;
    logic [LEN_W-1:0]     merged_reg;

    // Allocated-block table.
    logic [ADDR_BITS+LEN_W-1:0] used_mem [USED_SLOTS];
    logic [ADDR_BITS+LEN_W-1:0] used_rd_reg;
    logic [USED_SLOTS-1:0]      used_valid_reg;
    logic [UI_W-1:0]            uidx_reg;
    logic [UI_W-1:0]            chk_idx_reg;
    logic                       chk_vld_reg;
    logic [UI_W-1:0]            slot_reg;
    logic [LEN_W-1:0]           blk_len_reg;

    // Result state.
    logic [ADDR_BITS-1:0] grant_reg;
    logic [LEN_W-1:0]     total_reg;
    status_t              st_reg;
    logic                 m_tvalid_reg;
    logic [TDATA_W-1:0]   m_tdata_reg;

    logic [CNT_W-1:0]     nidx;
    logic [CNT_W-1:0]     rd_idx;
    logic [ADDR_BITS-1:0] rd_start;
    logic [LEN_W-1:0]     rd_len;
    logic [LEN_W-1:0]     rd_end;
    logic [LEN_W-1:0]     bend;
    logic [LEN_W-1:0]     sum_blk;
    logic [LEN_W-1:0]     sum_mrg;
    logic [LEN_W-1:0]     cfg_pages;
    logic [LEN_W-1:0]     cfg_len;
    logic                 fw_we;
    logic                 fw_start_we;
    logic [FI_W-1:0]      fw_idx;
    logic [ADDR_BITS-1:0] fw_start;
    logic [LEN_W-1:0]     fw_len;
    logic [ADDR_BITS-1:0] out_addr;

    // Free-list read port: the scanned entry, or the one after it while shifting.
    assign nidx     = fidx_reg + CNT_W'(1);
    assign rd_idx   = cmd.rd_next ? nidx : fidx_reg;
    assign rd_start = free_start_reg[rd_idx[FI_W-1:0]];
    assign rd_len   = free_len_reg[rd_idx[FI_W-1:0]];
    assign rd_end   = {1'b0, rd_start} + rd_len;
    assign bend     = {1'b0, addr_reg} + blk_len_reg;
    assign sum_blk  = rd_len + blk_len_reg;
    assign sum_mrg  = rd_len + merged_reg;

    // Pool length for a written page count, clamped to the address space; zero gives one page.
    always_comb
    begin
        if (cfg_wr_data == '0)
            cfg_pages = LEN_W'(1);
        else if (32'(cfg_wr_data) > 32'(MAX_PAGES))
            cfg_pages = LEN_W'(MAX_PAGES);
        else
            cfg_pages = LEN_W'(cfg_wr_data);
        cfg_len = cfg_pages << PAGE_SHIFT;
    end

    // Free-list write decode.
    always_comb
    begin
        fw_we       = 1'b1;
        fw_start_we = 1'b0;
        fw_idx      = fidx_reg[FI_W-1:0];
        fw_start    = rd_start;
        fw_len      = rd_len;
        case (cmd.fw_mode)
            FW_SPLIT:
            begin
                fw_start_we = 1'b1;
                fw_start    = rd_start + ADDR_BITS'(size_reg);
                fw_len      = rd_len - LEN_W'(size_reg);
            end
            FW_SHIFT:
            begin
                fw_start_we = 1'b1;
            end
            FW_APPEND:
            begin
                fw_start_we = 1'b1;
                fw_idx      = count_reg[FI_W-1:0];
                fw_start    = addr_reg;
                fw_len      = blk_len_reg;
            end
            FW_FRONT:
            begin
                fw_start_we = 1'b1;
                fw_start    = addr_reg;
                fw_len      = sum_blk;
            end
            FW_BACK:
            begin
                fw_len = sum_blk;
            end
            FW_JOIN_J:
            begin
                fw_len = sum_mrg;
            end
            FW_JOIN_H:
            begin
                fw_idx = hidx_reg[FI_W-1:0];
                fw_len = sum_mrg;
            end
            default:
            begin
                fw_we = 1'b0;
            end
        endcase
    end

    // Free-list storage; entry zero covers the whole pool after init.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_start_reg[0] <= '0;
            free_len_reg[0]   <= RESET_LEN;
        end
        else if (cfg_wr_en)
        begin
            free_start_reg[0] <= '0;
            free_len_reg[0]   <= cfg_len;
        end
        else if (fw_we)
        begin
            if (fw_start_we)
                free_start_reg[fw_idx] <= fw_start;
            free_len_reg[fw_idx] <= fw_len;
        end
    end

    // Free-list count and scan indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            fidx_reg  <= '0;
            hidx_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                count_reg <= CNT_W'(1);
            else if (cmd.fw_mode == FW_APPEND)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.cnt_dec)
                count_reg <= count_reg - CNT_W'(1);
            case (cmd.fidx_op)
                FI_CLR:    fidx_reg <= '0;
                FI_INC:    fidx_reg <= nidx;
                FI_LOAD_H: fidx_reg <= hidx_reg;
                default:   fidx_reg <= fidx_reg;
            endcase
            if (cmd.fw_mode == FW_FRONT || cmd.fw_mode == FW_BACK)
                hidx_reg <= fidx_reg;
        end
    end

    // Merged length of the grown extent, for a second merge.
    always_ff @(posedge clk)
    begin
        if (cmd.fw_mode == FW_FRONT || cmd.fw_mode == FW_BACK)
            merged_reg <= sum_blk;
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            cmd_free_reg <= s_tuser[0];
            size_reg     <= s_tdata[SIZE_W-1:0];
            addr_reg     <= ADDR_BITS'(s_tdata[SIZE_W +: RADDR_W]);
        end
    end

    // Allocated table scan index and read pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uidx_reg    <= '0;
            chk_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            slot_reg    <= '0;
        end
        else
        begin
            if (cmd.req_load)
                uidx_reg <= '0;
            else if (cmd.uidx_inc && uidx_reg != ULAST)
                uidx_reg <= uidx_reg + UI_W'(1);
            chk_idx_reg <= uidx_reg;
            chk_vld_reg <= cmd.scan;
            if (cmd.slot_alloc)
                slot_reg <= uidx_reg;
            else if (cmd.slot_hit)
                slot_reg <= chk_idx_reg;
        end
    end

    // Allocated table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.used_wr)
            used_mem[slot_reg] <= {grant_reg, LEN_W'(size_reg)};
        used_rd_reg <= used_mem[uidx_reg];
    end

    // Block length of the entry being freed.
    always_ff @(posedge clk)
    begin
        if (cmd.slot_hit)
            blk_len_reg <= used_rd_reg[LEN_W-1:0];
    end

    // Valid bits, granted address and bytes in use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_valid_reg <= '0;
            total_reg      <= '0;
            grant_reg      <= '0;
            st_reg         <= ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                used_valid_reg <= '0;
                total_reg      <= '0;
            end
            else if (cmd.used_wr)
            begin
                used_valid_reg[slot_reg] <= 1'b1;
                total_reg                <= total_reg + LEN_W'(size_reg);
            end
            else if (cmd.used_rel)
            begin
                used_valid_reg[slot_reg] <= 1'b0;
                total_reg                <= total_reg - blk_len_reg;
            end
            if (cmd.req_load)
                grant_reg <= '0;
            else if (cmd.grant_load)
                grant_reg <= rd_start;
            if (cmd.st_load)
                st_reg <= cmd.st_code;
        end
    end

    // Result register; a new request may be taken while it waits.
    assign out_addr = cmd_free_reg ? addr_reg : grant_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            m_tdata_reg <= {{(TDATA_W - STAT_W - RADDR_W - INUSE_W){1'b0}},
                            INUSE_W'(total_reg), RADDR_W'(out_addr), st_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.is_free     = cmd_free_reg;
        stat.size_zero   = (size_reg == '0);
        stat.uvalid      = used_valid_reg[uidx_reg];
        stat.ulast       = (uidx_reg == ULAST);
        stat.hit         = chk_vld_reg && used_valid_reg[chk_idx_reg]
                           && (used_rd_reg[LEN_W +: ADDR_BITS] == addr_reg);
        stat.chk_last    = chk_vld_reg && (chk_idx_reg == ULAST);
        stat.fend        = (fidx_reg >= count_reg);
        stat.list_full   = (count_reg == CNT_W'(FREE_SLOTS));
        stat.fit         = (CW'(rd_len) >= CW'(size_reg));
        stat.rest_zero   = (CW'(rd_len) == CW'(size_reg));
        stat.touch_front = (bend == {1'b0, rd_start});
        stat.touch_back  = (rd_end == {1'b0, addr_reg});
        stat.j_is_h      = (fidx_reg == hidx_reg);
        stat.shift_more  = (nidx < count_reg);
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

    // The list may run empty when the whole pool is granted, but never overflows.
    `FFCA_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(FREE_SLOTS))
    // A grant lands only in an empty table slot.
    `FFCA_ASSERT_IMPL(a_wr_empty_slot, clk, rst_n, cmd.used_wr, !used_valid_reg[slot_reg])
    // A release only retires a live block.
    `FFCA_ASSERT_IMPL(a_rel_live_slot, clk, rst_n, cmd.used_rel, used_valid_reg[slot_reg])

endmodule

`default_nettype wire

### rtl/core/ffca_ctrl.sv
// Controller state machine of the allocator: sequences the table scans,
// extent merges and list shifts. Depends on ffca_pkg and the macro header.
`default_nettype none
`include "first_fit_coalescing_allocator_defines.svh"

module ffca_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire ffca_pkg::dp_stat_t  stat,
    output ffca_pkg::ctrl_cmd_t      cmd
);
    import ffca_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_CHECK   = 12'b0000_0000_0010,
        S_USLOT   = 12'b0000_0000_0100,
        S_FSCAN_A = 12'b0000_0000_1000,
        S_SHIFT   = 12'b0000_0001_0000,
        S_UWRITE  = 12'b0000_0010_0000,
        S_UFIND   = 12'b0000_0100_0000,
        S_FSCAN_F = 12'b0000_1000_0000,
        S_JSCAN_A = 12'b0001_0000_0000,
        S_JSCAN_B = 12'b0010_0000_0000,
        S_RELEASE = 12'b0100_0000_0000,
        S_RESP    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_free)
                begin
                    // Start the table read pipeline right away.
                    cmd.scan     = 1'b1;
                    cmd.uidx_inc = 1'b1;
                    state_next   = S_UFIND;
                end
                else if (stat.size_zero)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_BAD_SIZE;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_USLOT;
                end
            end
            S_USLOT:
            begin
                if (!stat.uvalid)
                begin
                    cmd.slot_alloc = 1'b1;
                    cmd.fidx_op    = FI_CLR;
                    state_next     = S_FSCAN_A;
                end
                else if (stat.ulast)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_TABLE_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.uidx_inc = 1'b1;
                end
            end
            S_FSCAN_A:
            begin
                if (stat.fend)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NO_SPACE;
                    state_next  = S_RESP;
                end
                else if (stat.fit)
                begin
                    cmd.grant_load = 1'b1;
                    if (stat.rest_zero)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.fw_mode = FW_SPLIT;
                        state_next  = S_UWRITE;
                    end
                end
                else
                begin
                    cmd.fidx_op = FI_INC;
                end
            end
            S_SHIFT:
            begin
                cmd.rd_next = 1'b1;
                if (stat.shift_more)
                begin
                    cmd.fw_mode = FW_SHIFT;
                    cmd.fidx_op = FI_INC;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = stat.is_free ? S_RELEASE : S_UWRITE;
                end
            end
            S_UWRITE:
            begin
                cmd.used_wr = 1'b1;
                cmd.st_load = 1'b1;
                cmd.st_code = ST_OK;
                state_next  = S_RESP;
            end
            S_UFIND:
            begin
                cmd.scan     = 1'b1;
                cmd.uidx_inc = 1'b1;
                if (stat.hit)
                begin
                    cmd.slot_hit = 1'b1;
                    cmd.fidx_op  = FI_CLR;
                    state_next   = S_FSCAN_F;
                end
                else if (stat.chk_last)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_UNKNOWN;
                    state_next  = S_RESP;
                end
            end
            S_FSCAN_F:
            begin
                if (stat.fend)
                begin
                    if (stat.list_full)
                    begin
                        cmd.st_load = 1'b1;
                        cmd.st_code = ST_TABLE_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        cmd.fw_mode = FW_APPEND;
                        state_next  = S_RELEASE;
                    end
                end
                else if (stat.touch_front)
                begin
                    cmd.fw_mode = FW_FRONT;
                    cmd.fidx_op = FI_CLR;
                    state_next  = S_JSCAN_A;
                end
                else if (stat.touch_back)
                begin
                    cmd.fw_mode = FW_BACK;
                    cmd.fidx_op = FI_CLR;
                    state_next  = S_JSCAN_B;
                end
                else
                begin
                    cmd.fidx_op = FI_INC;
                end
            end
            S_JSCAN_A:
            begin
                // Look for an extent that ends where the freed block starts.
                if (stat.fend)
                begin
                    state_next = S_RELEASE;
                end
                else if (!stat.j_is_h && stat.touch_back)
                begin
                    cmd.fw_mode = FW_JOIN_J;
                    cmd.fidx_op = FI_LOAD_H;
                    state_next  = S_SHIFT;
                end
                else
                begin
                    cmd.fidx_op = FI_INC;
                end
            end
            S_JSCAN_B:
            begin
                // Look for an extent that starts where the freed block ends.
                if (stat.fend)
                begin
                    state_next = S_RELEASE;
                end
                else if (!stat.j_is_h && stat.touch_front)
                begin
                    cmd.fw_mode = FW_JOIN_H;
                    state_next  = S_SHIFT;
                end
                else
                begin
                    cmd.fidx_op = FI_INC;
                end
            end
            S_RELEASE:
            begin
                cmd.used_rel = 1'b1;
                cmd.st_load  = 1'b1;
                cmd.st_code  = ST_OK;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Once a request is taken, no other is taken until its result is queued.
    `FFCA_ASSERT_NEXT(a_accept_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // The result register is only loaded when it has room.
    `FFCA_ASSERT_IMPL(a_out_room, clk, rst_n, cmd.out_load, stat.out_free)
    // Every table commit is followed directly by the response step.
    `FFCA_ASSERT_NEXT(a_commit_resp, clk, rst_n, cmd.used_wr || cmd.used_rel, state_reg == S_RESP)

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the first-fit coalescing allocator.
// Drives allocate and free requests over the stream ports and checks each result against a
// behavioral pool model or a typed directed row. Depends on ffca_pkg and the allocator RTL only.
`default_nettype none

module tb;
    import ffca_pkg::*;

    localparam int NFREE = 16;
    localparam int NUSED = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 150;

    typedef struct {
        status_t     st;
        logic [19:0] addr;
        logic [20:0] inuse;
    } pool_result_t;

    typedef struct {
        logic        cmd;
        logic [20:0] size;
        logic [19:0] addr;
        bit          typed;
        status_t     st;
        logic [19:0] baddr;
        logic [20:0] inuse;
    } req_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [PAGES_W-1:0]  cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;

    // Pool model state.
    int unsigned ext_base[NFREE];
    int unsigned ext_len[NFREE];
    int          ext_cnt;
    int unsigned blk_base[NUSED];
    int unsigned blk_len[NUSED];
    bit          blk_live[NUSED];
    int unsigned bytes_held;

    pool_result_t pending_results[$];
    int  errors = 0;
    int  cycles = 0;
    int  n_status[5];
    bit  no_idle = 1'b0;
    int  stall_left = 0;

    first_fit_coalescing_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // req_size, req_addr
        .s_tuser     (s_tuser),   // cmd
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)    // status, block_addr, bytes_in_use
    );

    // Clock generation.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Bring the model back to one extent over the whole pool.
    function automatic void pool_init(input int unsigned pages);
        if (pages == 0) pages = 1;
        if (pages > 256) pages = 256;
        ext_base[0] = 0;
        ext_len[0] = pages * 4096;
        ext_cnt = 1;
        for (int i = 0; i < NUSED; i++) blk_live[i] = 1'b0;
        bytes_held = 0;
    endfunction

    // Drop one extent; later entries move down to keep list order.
    function automatic void drop_extent(input int idx);
        for (int k = idx; k + 1 < ext_cnt; k++)
        begin
            ext_base[k] = ext_base[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        ext_cnt--;
    endfunction

    function automatic status_t pool_alloc(input int unsigned size, output int unsigned addr);
        int slot;
        int unsigned base;
        slot = -1;
        addr = 0;
        if (size == 0) return ST_BAD_SIZE;
        for (int i = 0; i < NUSED; i++)
        begin
            if (!blk_live[i])
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0) return ST_TABLE_FULL;
        for (int i = 0; i < ext_cnt; i++)
        begin
            if (ext_len[i] >= size)
            begin
                base = ext_base[i];
                if (ext_len[i] > size)
                begin
                    ext_base[i] = base + size;
                    ext_len[i] = ext_len[i] - size;
                end
                else
                    drop_extent(i);
                blk_base[slot] = base;
                blk_len[slot] = size;
                blk_live[slot] = 1'b1;
                bytes_held += size;
                addr = base;
                return ST_OK;
            end
        end
        return ST_NO_SPACE;
    endfunction

    function automatic status_t pool_release(input int unsigned addr);
        int slot;
        int unsigned size, bend;
        bit merged;
        slot = -1;
        merged = 1'b0;
        for (int i = 0; i < NUSED; i++)
        begin
            if (blk_live[i] && blk_base[i] == addr)
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0) return ST_UNKNOWN;
        size = blk_len[slot];
        bend = addr + size;
        for (int i = 0; i < ext_cnt && !merged; i++)
        begin
            if (bend == ext_base[i])
            begin
                ext_base[i] = addr;
                ext_len[i] += size;
                for (int j = 0; j < ext_cnt; j++)
                begin
                    if (j != i && ext_base[j] + ext_len[j] == addr)
                    begin
                        ext_len[j] += ext_len[i];
                        drop_extent(i);
                        break;
                    end
                end
                merged = 1'b1;
            end
            else if (ext_base[i] + ext_len[i] == addr)
            begin
                ext_len[i] += size;
                for (int j = 0; j < ext_cnt; j++)
                begin
                    if (j != i && ext_base[j] == bend)
                    begin
                        ext_len[i] += ext_len[j];
                        drop_extent(j);
                        break;
                    end
                end
                merged = 1'b1;
            end
        end
        if (!merged)
        begin
            if (ext_cnt >= NFREE) return ST_TABLE_FULL;
            ext_base[ext_cnt] = addr;
            ext_len[ext_cnt] = size;
            ext_cnt++;
        end
        blk_live[slot] = 1'b0;
        bytes_held -= size;
        return ST_OK;
    endfunction

    function automatic pool_result_t pool_request(input logic cmd, input logic [20:0] size,
                                                  input logic [19:0] addr);
        pool_result_t r;
        int unsigned granted;
        if (cmd == CMD_ALLOC)
        begin
            r.st = pool_alloc(size, granted);
            r.addr = granted[19:0];
        end
        else
        begin
            r.st = pool_release(addr);
            r.addr = addr;
        end
        r.inuse = bytes_held[20:0];
        return r;
    endfunction

    // Gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Issue one request and hold it until accepted.
    task automatic send_request(input logic cmd, input logic [20:0] size,
                                input logic [19:0] addr, input bit typed,
                                input pool_result_t typed_res);
        pool_result_t r;
        int gap;
        r = pool_request(cmd, size, addr);
        if (typed) r = typed_res;
        pending_results.insert(pending_results.size(), r);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, addr, size};
        do @(posedge clk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_pool(input logic [PAGES_W-1:0] pages);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pages;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pool_init(pages);
    endtask

    // Result side: random stalls, then check each result in order.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left <= pick_gap();
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                pool_result_t e;
                e = pending_results.pop_front();
                if (e.st <= ST_BAD_SIZE) n_status[e.st]++;
                if (m_tdata[2:0] != e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[22:3] != e.addr)
                begin
                    $display("%0t: block_addr expected %h actual %h", $time, e.addr,
                             m_tdata[22:3]);
                    errors++;
                end
                if (m_tdata[43:23] != e.inuse)
                begin
                    $display("%0t: bytes_in_use expected %0d actual %0d", $time, e.inuse,
                             m_tdata[43:23]);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Directed requests: corner sizes and addresses, then split and merge patterns.
    req_row_t directed[14] = '{
        '{CMD_ALLOC, 21'd0,       20'd0,       1'b1, ST_BAD_SIZE, 20'd0,       21'd0},
        '{CMD_ALLOC, 21'd1048576, 20'hFFFFF,   1'b1, ST_OK,       20'd0,       21'd1048576},
        '{CMD_ALLOC, 21'd1,       20'd0,       1'b1, ST_NO_SPACE, 20'd0,       21'd1048576},
        '{CMD_FREE,  21'h1FFFFF,  20'hFFFFF,   1'b1, ST_UNKNOWN,  20'hFFFFF,   21'd1048576},
        '{CMD_FREE,  21'd0,       20'd0,       1'b1, ST_OK,       20'd0,       21'd0},
        '{CMD_ALLOC, 21'h1FFFFF,  20'd0,       1'b1, ST_NO_SPACE, 20'd0,       21'd0},
        '{CMD_ALLOC, 21'd4096,    20'd0,       1'b0, ST_OK,       20'd0,       21'd0},
        '{CMD_ALLOC, 21'd1,       20'd0,       1'b0, ST_OK,       20'd0,       21'd0},
        '{CMD_ALLOC, 21'd8191,    20'd0,       1'b0, ST_OK,       20'd0,       21'd0},
        '{CMD_FREE,  21'd0,       20'd4096,    1'b0, ST_OK,       20'd0,       21'd0},
        '{CMD_FREE,  21'd0,       20'd0,       1'b0, ST_OK,       20'd0,       21'd0},
        '{CMD_FREE,  21'd0,       20'd4097,    1'b0, ST_OK,       20'd0,       21'd0},
        '{CMD_ALLOC, 21'd1048576, 20'd0,       1'b0, ST_OK,       20'd0,       21'd0},
        '{CMD_FREE,  21'd0,       20'd0,       1'b0, ST_OK,       20'd0,       21'd0}
    };

    // Pool sizes walked phase by phase; the first phase runs on the reset value.
    int pool_plan[8] = '{256, 0, 1, 511, 300, 7, 2, -1};

    initial
    begin
        pool_result_t typed_res;
        int unsigned live_addrs[$];
        int r, pick;
        logic [20:0] sz;
        logic [19:0] ad;

        for (int i = 0; i < 5; i++) n_status[i] = 0;
        pool_init(256);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            typed_res.st = directed[i].st;
            typed_res.addr = directed[i].baddr;
            typed_res.inuse = directed[i].inuse;
            send_request(directed[i].cmd, directed[i].size, directed[i].addr,
                         directed[i].typed, typed_res);
        end

        foreach (pool_plan[p])
        begin
            // Reconfigure only once everything has come back.
            drain();
            if (p > 0)
                write_pool(pool_plan[p] < 0 ? PAGES_W'($urandom_range(0, 511))
                                            : PAGES_W'(pool_plan[p]));
            no_idle = (p == 2);
            for (int n = 0; n < 112; n++)
            begin
                live_addrs.delete();
                for (int k = 0; k < NUSED; k++)
                    if (blk_live[k]) live_addrs.insert(live_addrs.size(), blk_base[k]);
                r = $urandom_range(0, 99);
                sz = '0;
                ad = 20'($urandom);
                if (r < 52)
                begin
                    // Mostly small allocations so that the tables fill and fragment.
                    pick = $urandom_range(0, 9);
                    if (pick < 5) sz = 21'($urandom_range(1, 64));
                    else if (pick < 8) sz = 21'($urandom_range(1, 8192));
                    else if (pick < 9) sz = 21'($urandom_range(1, 262144));
                    else sz = 21'($urandom_range(1, 1048576));
                    send_request(CMD_ALLOC, sz, ad, 1'b0, typed_res);
                end
                else if (r < 90 && live_addrs.size() != 0)
                begin
                    ad = 20'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
                    sz = 21'($urandom);
                    send_request(CMD_FREE, sz, ad, 1'b0, typed_res);
                end
                else
                begin
                    // Noise: zero or oversized allocations, frees of stray addresses.
                    pick = $urandom_range(0, 3);
                    if (pick == 0) send_request(CMD_ALLOC, 21'd0, ad, 1'b0, typed_res);
                    else if (pick == 1)
                        send_request(CMD_ALLOC, 21'($urandom_range(1048576, 2097151)), ad,
                                     1'b0, typed_res);
                    else if (pick == 2 && live_addrs.size() != 0)
                        send_request(CMD_FREE, 21'($urandom),
                                     20'(live_addrs[0] + $urandom_range(1, 3)), 1'b0,
                                     typed_res);
                    else send_request(CMD_FREE, 21'($urandom), ad, 1'b0, typed_res);
                end
            end
        end

        drain();
        $display("Covered %0d ok, %0d no_space, %0d unknown_address, %0d table_full,",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        $display("%0d bad_size results over eight pool sizes in %0d cycles.",
                 n_status[4], cycles);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
